// ===== src/assert_macros.svh =====
// assertion macros for the rtl files; the top level includes them
// bodies use the clk and rst_n names of the module that includes this file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== src/fbg_pkg.sv =====
// package for the floppy board glue logic: beat types, codes and constants
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fbg_pkg;

    localparam int DRV_SLOTS      = 4;
    localparam int TRK_W          = 7;
    localparam int DEF_NUM_DRIVES = 4;
    localparam int DEF_MAX_TRACK  = 94;

    localparam logic [2:0] NO_DRIVE     = 3'd4;
    localparam logic [7:0] STATUS_BASE  = 8'h30;
    localparam logic [7:0] TRACK2_NONE  = 8'd2;
    localparam logic [6:0] TCOUNT_40    = 7'd40;
    localparam logic [6:0] TCOUNT_77    = 7'd77;
    localparam logic [6:0] TCOUNT_80    = 7'd80;

    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    typedef enum logic [1:0] {
        CMD_PORT   = 2'd0,
        CMD_STEP   = 2'd1,
        CMD_STATUS = 2'd2,
        CMD_SPARE  = 2'd3
    } cmd_t;

    typedef enum logic [PADDR_W-1:0] {
        ADDR_DRIVE_TYPE = 3'd0,
        ADDR_SIDE_MAP   = 3'd4
    } reg_addr_t;

    typedef enum logic [2:0] {
        MEDIA_525_180K = 3'd0,
        MEDIA_525_360K = 3'd1,
        MEDIA_525_12M  = 3'd2,
        MEDIA_35_360K  = 3'd3,
        MEDIA_35_720K  = 3'd4,
        MEDIA_35_144M  = 3'd5,
        MEDIA_8_1M     = 3'd6,
        MEDIA_UNKNOWN  = 3'd7
    } media_t;

    localparam logic [1:0] MAP_REVERSED = 2'd0;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] port_b_value;
        logic       ca2_level;
        logic       cb2_level;
        logic       step_inward;
        logic       fdc_drq;
        logic       fdc_irq;
    } cmd_beat_t;

    typedef struct packed {
        logic [7:0] status_byte;
        logic [2:0] drive_selected;
        logic       side_select;
        logic       mfm_density;
        logic       fast_clock;
        logic       auto_index;
        logic       index_level;
        logic [7:0] fdc_track;
        logic       track_zero;
        logic       spin_360;
        logic [6:0] track_count;
        logic [1:0] side_mapping;
    } res_beat_t;

    typedef struct packed {
        logic [11:0] drive_type_codes;
        logic [7:0]  side_mapping_codes;
    } cfg_t;

endpackage

`default_nettype wire

// ===== src/fbg_regs.sv =====
// apb configuration registers: drive media types and side mappings
// depends on fbg_pkg
`timescale 1ns / 1ps
`default_nettype none

module fbg_regs
    import fbg_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output cfg_t                    cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr)
                ADDR_DRIVE_TYPE: cfg_next.drive_type_codes   = pwdata[11:0];
                ADDR_SIDE_MAP:   cfg_next.side_mapping_codes = pwdata[7:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            ADDR_DRIVE_TYPE: prdata = {20'd0, cfg_reg.drive_type_codes};
            ADDR_SIDE_MAP:   prdata = {24'd0, cfg_reg.side_mapping_codes};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== src/fbg_core.sv =====
// port latches, drive select, index counter and per-drive track counters
// computes the next state and the result for the beat being processed; depends on fbg_pkg
`timescale 1ns / 1ps
`default_nettype none

module fbg_core
    import fbg_pkg::*;
#(
    parameter int NUM_DRIVES = DEF_NUM_DRIVES,
    parameter int MAX_TRACK  = DEF_MAX_TRACK
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      step,
    input  cmd_beat_t      item,
    input  cfg_t           cfg,
    output res_beat_t      result
);

    logic [7:0]       port_b_reg, port_b_next;
    logic             ca2_reg, ca2_next;
    logic             cb2_reg, cb2_next;
    logic [2:0]       drive_reg, drive_next;
    logic [1:0]       index_reg, index_next;
    logic [TRK_W-1:0] tracks_reg [NUM_DRIVES];
    logic [TRK_W-1:0] tracks_next [NUM_DRIVES];

    logic [7:0]       delta;
    logic [3:0]       sel_code;
    logic [2:0]       decoded;
    logic             cur_valid;
    logic             nxt_valid;
    logic [TRK_W-1:0] sel_track;
    logic [2:0]       sel_type;
    logic [1:0]       sel_map;

    // select code is the low nibble with bit 3 inverted
    always_comb
    begin
        sel_code = item.port_b_value[3:0] ^ 4'b1000;
        case (sel_code)
            4'b0001: decoded = 3'd0;
            4'b0010: decoded = 3'd1;
            4'b0100: decoded = 3'd2;
            4'b1000: decoded = 3'd3;
            default: decoded = NO_DRIVE;
        endcase
        if (decoded >= 3'(NUM_DRIVES))
            decoded = NO_DRIVE;
    end

    assign delta     = port_b_reg ^ item.port_b_value;
    assign cur_valid = drive_reg < 3'(NUM_DRIVES);

    always_comb
    begin
        port_b_next = port_b_reg;
        ca2_next    = ca2_reg;
        cb2_next    = cb2_reg;
        drive_next  = drive_reg;
        index_next  = index_reg;
        for (int i = 0; i < NUM_DRIVES; i++)
            tracks_next[i] = tracks_reg[i];

        case (item.cmd)
            CMD_PORT:
            begin
                port_b_next = item.port_b_value;
                ca2_next    = item.ca2_level;
                cb2_next    = item.cb2_level;
                if (delta[3:0] != 4'd0)
                    drive_next = decoded;
                // falling edge of pb7 clocks the manual index counter
                if (delta[7] && !item.port_b_value[7])
                    index_next = index_reg + 2'd1;
            end
            CMD_STEP:
            begin
                for (int i = 0; i < NUM_DRIVES; i++)
                begin
                    if (cur_valid && drive_reg == 3'(i))
                    begin
                        if (item.step_inward)
                        begin
                            if (tracks_reg[i] < TRK_W'(MAX_TRACK))
                                tracks_next[i] = tracks_reg[i] + 1'b1;
                        end
                        else if (tracks_reg[i] != '0)
                        begin
                            tracks_next[i] = tracks_reg[i] - 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                port_b_next = port_b_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_b_reg <= '0;
            ca2_reg    <= 1'b0;
            cb2_reg    <= 1'b0;
            drive_reg  <= NO_DRIVE;
            index_reg  <= '0;
            for (int i = 0; i < NUM_DRIVES; i++)
                tracks_reg[i] <= '0;
        end
        else if (step)
        begin
            port_b_reg <= port_b_next;
            ca2_reg    <= ca2_next;
            cb2_reg    <= cb2_next;
            drive_reg  <= drive_next;
            index_reg  <= index_next;
            for (int i = 0; i < NUM_DRIVES; i++)
                tracks_reg[i] <= tracks_next[i];
        end
    end

    // result describes the state after this beat
    assign nxt_valid = drive_next < 3'(NUM_DRIVES);

    always_comb
    begin
        sel_track = '0;
        for (int i = 0; i < NUM_DRIVES; i++)
            if (drive_next == 3'(i))
                sel_track = tracks_next[i];
        sel_type = '0;
        sel_map  = '0;
        for (int i = 0; i < DRV_SLOTS; i++)
        begin
            if (drive_next == 3'(i))
            begin
                sel_type = cfg.drive_type_codes[3*i +: 3];
                sel_map  = cfg.side_mapping_codes[2*i +: 2];
            end
        end
    end

    always_comb
    begin
        result.status_byte = STATUS_BASE
                           | {item.fdc_drq, item.fdc_irq, 2'b00, port_b_next[5],
                              cb2_next, port_b_next[6], ca2_next};
        result.side_select = !port_b_next[4];
        result.mfm_density = !port_b_next[5];
        result.fast_clock  = !port_b_next[6];
        result.auto_index  = !cb2_next;
        result.index_level = cb2_next && index_next[1];

        result.drive_selected = NO_DRIVE;
        result.fdc_track      = TRACK2_NONE;
        result.track_zero     = 1'b0;
        result.spin_360       = 1'b0;
        result.track_count    = TCOUNT_40;
        result.side_mapping   = MAP_REVERSED;
        if (nxt_valid)
        begin
            result.drive_selected = drive_next;
            result.fdc_track      = {sel_track, 1'b0};
            result.track_zero     = sel_track == '0;
            result.spin_360       = sel_type == MEDIA_525_12M || sel_type == MEDIA_8_1M;
            case (sel_type)
                MEDIA_8_1M:     result.track_count = TCOUNT_77;
                MEDIA_525_12M,
                MEDIA_35_360K,
                MEDIA_35_720K,
                MEDIA_35_144M:  result.track_count = TCOUNT_80;
                default:        result.track_count = TCOUNT_40;
            endcase
            result.side_mapping = (sel_map == 2'd3) ? MAP_REVERSED : sel_map;
        end
    end

endmodule

`default_nettype wire

// ===== src/floppy_board_glue_logic_unit.sv =====
// top level of the floppy board glue logic: input stage, core, result register
// depends on fbg_pkg, fbg_regs, fbg_core and assert_macros.svh
//
//   channel  | valid      | stall      | beat
//   ---------+------------+------------+------------------------------
//   command  | cmd_valid  | cmd_stall  | cmd_beat (port/step/status)
//   result   | res_valid  | res_stall  | res_beat (status and drive)
//   config   | apb psel/penable/pwrite, always ready
//
// one beat per cycle sustained while the result is not stalled; a command passes through
// the input register, then once through the core into the result register
// reset clears the latches, the index counter and all tracks, no drive selected
// a stalled result holds; the input register still takes a beat while it is empty
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module floppy_board_glue_logic_unit
    import fbg_pkg::*;
#(
    parameter int NUM_DRIVES = DEF_NUM_DRIVES,
    parameter int MAX_TRACK  = DEF_MAX_TRACK
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    output logic                    cmd_stall,
    input  cmd_beat_t               cmd_beat,
    output logic                    res_valid,
    input  wire logic               res_stall,
    output res_beat_t               res_beat,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    logic      in_valid_reg, in_valid_next;
    cmd_beat_t in_beat_reg;
    logic      out_valid_reg, out_valid_next;
    res_beat_t out_beat_reg;
    res_beat_t core_result;
    cfg_t      cfg;
    logic      advance;
    logic      cmd_take;
    logic      no_drive_res;

    fbg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fbg_core #(
        .NUM_DRIVES (NUM_DRIVES),
        .MAX_TRACK  (MAX_TRACK)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_beat_reg),
        .cfg    (cfg),
        .result (core_result)
    );

    // input beat moves on when the result register is free or being drained
    assign advance   = in_valid_reg && (!out_valid_reg || !res_stall);
    assign cmd_stall = in_valid_reg && !advance;
    assign cmd_take  = cmd_valid && !cmd_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (cmd_take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !res_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
            in_beat_reg <= cmd_beat;
        if (advance)
            out_beat_reg <= core_result;
    end

    assign res_valid = out_valid_reg;
    assign res_beat  = out_beat_reg;

    assign no_drive_res = res_valid && res_beat.drive_selected == NO_DRIVE;

    `ASSERT_IMPLY(a_track_zero, res_valid, res_beat.track_zero == (res_beat.fdc_track == 8'd0))
    `ASSERT_IMPLY(a_no_drive, no_drive_res, res_beat.fdc_track == TRACK2_NONE)
    `ASSERT_IMPLY(a_no_drive_cnt, no_drive_res, res_beat.track_count == TCOUNT_40)
    `ASSERT_NEXT(a_drain, res_valid && !res_stall && !advance, !res_valid)
    `ASSERT_NEXT(a_hold_in, in_valid_reg && !advance, in_valid_reg)

endmodule

`default_nettype wire

// ===== sim/floppy_board_glue_logic_unit_test.sv =====
// testbench for floppy_board_glue_logic_unit: directed table, then random drive/step sessions
// every result beat is checked against a behavioral view of the board or a fixed table row; needs fbg_pkg only
`timescale 1ns / 1ps

module floppy_board_glue_logic_unit_test;
    import fbg_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 80;
    localparam int PHASE_ITEMS    = 100;
    // low nibble of port b that picks drive 0..3 (pb3 is inverted)
    localparam logic [3:0] SEL_NIBBLE [4] = '{4'h9, 4'hA, 4'hC, 4'h0};

    typedef struct {
        cmd_beat_t beat;
        bit        fixed;
        res_beat_t want;
    } row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cmd_valid = 1'b0;
    logic               cmd_stall;
    cmd_beat_t          cmd_beat = '0;
    logic               res_valid;
    logic               res_stall = 1'b0;
    res_beat_t          res_beat;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // typed expectation that travels with the offered beat
    logic      row_fixed = 1'b0;
    res_beat_t row_expect = '0;

    // board view kept by the testbench
    logic [11:0] media_cfg = '0;
    logic [7:0]  side_cfg = '0;
    logic [7:0]  pb_lat = '0;
    logic        ca2_lat = 1'b0;
    logic        cb2_lat = 1'b0;
    logic [2:0]  drv_sel = NO_DRIVE;
    logic [1:0]  idx_cnt = '0;
    logic [6:0]  track [4] = '{default: '0};

    res_beat_t view_q [$];
    row_t      rows [$];
    cfg_t      cfg_plan [5];
    int        mismatches = 0;
    int        idle_cycles = 0;
    int        items = 0;
    bit        calm = 1'b0;
    bit        hold_req = 1'b0;
    logic [3:0] last_low = '0;

    floppy_board_glue_logic_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_beat  (cmd_beat),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_beat  (res_beat),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // applies one command to the board view and returns what the board shows after it
    function automatic res_beat_t board_view(input cmd_beat_t b);
        res_beat_t  r;
        logic [7:0] delta;
        media_t     media;
        logic [1:0] mc;
        int         d;
        case (cmd_t'(b.cmd))
            CMD_PORT:
            begin
                delta = pb_lat ^ b.port_b_value;
                pb_lat = b.port_b_value;
                ca2_lat = b.ca2_level;
                cb2_lat = b.cb2_level;
                if (delta[3:0] != 4'h0)
                begin
                    case (b.port_b_value[3:0] ^ 4'h8)
                        4'h1: drv_sel = 3'd0;
                        4'h2: drv_sel = 3'd1;
                        4'h4: drv_sel = 3'd2;
                        4'h8: drv_sel = 3'd3;
                        default: drv_sel = NO_DRIVE;
                    endcase
                end
                // manual index advances on a falling pb7
                if (delta[7] && !b.port_b_value[7])
                    idx_cnt = idx_cnt + 2'd1;
            end
            CMD_STEP:
            begin
                if (drv_sel != NO_DRIVE)
                begin
                    d = drv_sel;
                    if (b.step_inward)
                    begin
                        if (track[d] < DEF_MAX_TRACK)
                            track[d] = track[d] + 7'd1;
                    end
                    else if (track[d] != 7'd0)
                    begin
                        track[d] = track[d] - 7'd1;
                    end
                end
            end
            default: ;
        endcase

        r.status_byte = STATUS_BASE | {b.fdc_drq, b.fdc_irq, 2'b00, pb_lat[5], cb2_lat,
                                       pb_lat[6], ca2_lat};
        r.drive_selected = NO_DRIVE;
        r.side_select = ~pb_lat[4];
        r.mfm_density = ~pb_lat[5];
        r.fast_clock = ~pb_lat[6];
        r.auto_index = ~cb2_lat;
        r.index_level = cb2_lat & idx_cnt[1];
        r.fdc_track = TRACK2_NONE;
        r.track_zero = 1'b0;
        r.spin_360 = 1'b0;
        r.track_count = TCOUNT_40;
        r.side_mapping = MAP_REVERSED;
        if (drv_sel != NO_DRIVE)
        begin
            d = drv_sel;
            media = media_t'(media_cfg[3*d +: 3]);
            mc = side_cfg[2*d +: 2];
            r.drive_selected = drv_sel;
            r.fdc_track = {track[d], 1'b0};
            r.track_zero = (track[d] == 7'd0);
            r.spin_360 = (media == MEDIA_525_12M) || (media == MEDIA_8_1M);
            if (media == MEDIA_8_1M)
                r.track_count = TCOUNT_77;
            else if (media inside {MEDIA_525_12M, MEDIA_35_360K, MEDIA_35_720K, MEDIA_35_144M})
                r.track_count = TCOUNT_80;
            r.side_mapping = (mc == 2'd3) ? MAP_REVERSED : mc;
        end
        return r;
    endfunction

    function automatic cmd_beat_t make_cmd(input cmd_t c, input logic [7:0] pb, input bit ca2,
                                           input bit cb2, input bit inw, input bit drq,
                                           input bit irq);
        cmd_beat_t b;
        b.cmd = c;
        b.port_b_value = pb;
        b.ca2_level = ca2;
        b.cb2_level = cb2;
        b.step_inward = inw;
        b.fdc_drq = drq;
        b.fdc_irq = irq;
        return b;
    endfunction

    function automatic cmd_beat_t noise_cmd();
        cmd_beat_t b;
        b.cmd = 2'($urandom_range(0, 3));
        b.port_b_value = 8'($urandom_range(0, 255));
        b.ca2_level = 1'($urandom_range(0, 1));
        b.cb2_level = 1'($urandom_range(0, 1));
        b.step_inward = 1'($urandom_range(0, 1));
        b.fdc_drq = 1'($urandom_range(0, 1));
        b.fdc_irq = 1'($urandom_range(0, 1));
        return b;
    endfunction

    task automatic add_row(input cmd_beat_t b, input bit fx, input res_beat_t w);
        row_t r;
        r.beat = b;
        r.fixed = fx;
        r.want = w;
        rows.push_back(r);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // offers one beat and returns at the edge that accepts it, valid still high
    task automatic offer(input cmd_beat_t b, input bit fx, input res_beat_t fv);
        while (!calm && $urandom_range(0, 99) < 14)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_beat <= b;
        row_fixed <= fx;
        row_expect <= fv;
        if (cmd_t'(b.cmd) == CMD_PORT)
            last_low = b.port_b_value[3:0];
        items++;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
    endtask

    task automatic drain();
        cmd_valid <= 1'b0;
        do
            @(posedge clk);
        while (view_q.size() != 0);
        // two-stage pipe, leave a few spare cycles
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input reg_addr_t a, input logic [PDATA_W-1:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= a;
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (a)
            ADDR_DRIVE_TYPE: media_cfg = v[11:0];
            ADDR_SIDE_MAP:   side_cfg = v[7:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // select a drive (or a random nibble), then a burst of steps; short bursts mix in a few port and status beats
    task automatic run_session(input bit long_run, input bit inward);
        cmd_beat_t b;
        int        n;
        int        pick;
        b = noise_cmd();
        b.cmd = CMD_PORT;
        pick = $urandom_range(0, 4);
        if (pick < 4)
            b.port_b_value[3:0] = SEL_NIBBLE[pick];
        offer(b, 1'b0, '0);
        n = long_run ? $urandom_range(96, 100) : $urandom_range(1, 12);
        repeat (n)
        begin
            b = noise_cmd();
            pick = $urandom_range(0, 9);
            if (long_run || pick < 7)
            begin
                b.cmd = CMD_STEP;
                b.step_inward = (long_run || $urandom_range(0, 3) != 0) ? inward : !inward;
            end
            else if (pick < 9)
            begin
                // side, density, clock and index bits only
                b.cmd = CMD_PORT;
                b.port_b_value[3:0] = last_low;
            end
            else
            begin
                b.cmd = CMD_STATUS;
            end
            offer(b, 1'b0, '0);
        end
    endtask

    // scoreboard and watchdog
    always @(posedge clk)
    begin
        res_beat_t want;
        if (rst_n)
        begin
            if (cmd_valid && !cmd_stall)
            begin
                want = board_view(cmd_beat);
                if (row_fixed)
                    want = row_expect;
                view_q.push_back(want);
            end
            if (res_valid && !res_stall)
            begin
                if (view_q.size() == 0)
                begin
                    $display("%0t ns: result beat with nothing expected, got %h", $time,
                             res_beat);
                    mismatches++;
                end
                else
                begin
                    want = view_q.pop_front();
                    check_field("status_byte", want.status_byte, res_beat.status_byte);
                    check_field("drive_selected", want.drive_selected, res_beat.drive_selected);
                    check_field("side_select", want.side_select, res_beat.side_select);
                    check_field("mfm_density", want.mfm_density, res_beat.mfm_density);
                    check_field("fast_clock", want.fast_clock, res_beat.fast_clock);
                    check_field("auto_index", want.auto_index, res_beat.auto_index);
                    check_field("index_level", want.index_level, res_beat.index_level);
                    check_field("fdc_track", want.fdc_track, res_beat.fdc_track);
                    check_field("track_zero", want.track_zero, res_beat.track_zero);
                    check_field("spin_360", want.spin_360, res_beat.spin_360);
                    check_field("track_count", want.track_count, res_beat.track_count);
                    check_field("side_mapping", want.side_mapping, res_beat.side_mapping);
                end
            end
            if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t ns: no beat moved for %0d cycles", $time, idle_cycles);
                $display("floppy_board_glue_logic_unit test failed");
                $finish;
            end
        end
    end

    // result side: random stalls, one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            res_stall <= !calm && ($urandom_range(0, 99) < 14);
        end
    end

    initial
    begin
        res_beat_t w;
        int        goal;
        int        sess;
        cfg_plan[0] = '{12'hFFF, 8'hFF};
        cfg_plan[1] = '{12'h688, 8'hE4};   // media 3,2,1,0 and maps 3,2,1,0
        cfg_plan[2] = '{12'hFAC, 8'h1B};   // media 7,6,5,4 and maps 0,1,2,3
        cfg_plan[3] = '{12'h000, 8'h00};
        cfg_plan[4] = '{12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255))};

        // after reset: no drive, all port bits low
        w = '{8'hF0, NO_DRIVE, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, TRACK2_NONE, 1'b0, 1'b0,
              TCOUNT_40, MAP_REVERSED};
        add_row(make_cmd(CMD_STATUS, 8'h00, 0, 0, 0, 1, 1), 1'b1, w);
        w.status_byte = 8'h30;
        add_row(make_cmd(CMD_STEP, 8'h00, 0, 0, 1, 0, 0), 1'b1, w);
        // rewriting the reset value keeps no drive
        w.status_byte = 8'h35;
        w.auto_index = 1'b0;
        add_row(make_cmd(CMD_PORT, 8'h00, 1, 1, 0, 0, 0), 1'b1, w);
        w = '{8'h3A, NO_DRIVE, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, TRACK2_NONE, 1'b0, 1'b0,
              TCOUNT_40, MAP_REVERSED};
        add_row(make_cmd(CMD_PORT, 8'hFF, 0, 0, 0, 0, 0), 1'b1, w);
        add_row(make_cmd(CMD_PORT, 8'h7F, 1, 1, 0, 1, 0), 1'b0, '0);
        add_row(make_cmd(CMD_PORT, 8'hF7, 0, 1, 0, 0, 1), 1'b0, '0);
        add_row(make_cmd(CMD_PORT, 8'h77, 1, 1, 0, 0, 0), 1'b0, '0);
        add_row(make_cmd(CMD_PORT, 8'h09, 0, 1, 0, 0, 0), 1'b0, '0);
        add_row(make_cmd(CMD_STEP, 8'h09, 0, 0, 0, 0, 0), 1'b0, '0);
        repeat (3) add_row(make_cmd(CMD_STEP, 8'hFF, 1, 1, 1, 1, 1), 1'b0, '0);
        add_row(make_cmd(CMD_STEP, 8'h00, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(make_cmd(CMD_PORT, 8'h0A, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(make_cmd(CMD_STEP, 8'h00, 0, 0, 1, 0, 0), 1'b0, '0);
        add_row(make_cmd(CMD_PORT, 8'h2C, 1, 0, 0, 1, 1), 1'b0, '0);
        add_row(make_cmd(CMD_PORT, 8'h50, 0, 1, 0, 0, 0), 1'b0, '0);
        add_row(make_cmd(CMD_STEP, 8'h00, 0, 0, 1, 1, 0), 1'b0, '0);
        add_row(make_cmd(CMD_PORT, 8'h08, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(make_cmd(CMD_STEP, 8'h00, 0, 0, 1, 0, 0), 1'b0, '0);
        add_row(make_cmd(CMD_SPARE, 8'hA5, 1, 1, 1, 1, 1), 1'b0, '0);
        add_row(make_cmd(CMD_PORT, 8'h89, 1, 1, 0, 0, 0), 1'b0, '0);
        add_row(make_cmd(CMD_PORT, 8'h19, 0, 1, 0, 0, 0), 1'b0, '0);
        add_row(make_cmd(CMD_STATUS, 8'h00, 0, 0, 0, 1, 0), 1'b0, '0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            offer(rows[i].beat, rows[i].fixed, rows[i].want);

        for (int p = 0; p < 5; p++)
        begin
            drain();
            write_reg(ADDR_DRIVE_TYPE, PDATA_W'(cfg_plan[p].drive_type_codes));
            write_reg(ADDR_SIDE_MAP, PDATA_W'(cfg_plan[p].side_mapping_codes));
            calm = (p == 2);
            if (p == 0)
                hold_req = 1'b1;
            goal = items + PHASE_ITEMS;
            sess = 0;
            while (items < goal)
            begin
                if (p == 1 && sess == 6)
                    drain();
                if (sess > 0 && $urandom_range(0, 4) == 0)
                begin
                    repeat ($urandom_range(1, 4)) offer(noise_cmd(), 1'b0, '0);
                end
                else
                begin
                    run_session((sess == 0 && p < 2) || $urandom_range(0, 24) == 0,
                                (p == 0) ? 1'b1 : (p == 1) ? 1'b0 : 1'($urandom_range(0, 1)));
                end
                sess++;
            end
        end
        calm = 1'b0;

        drain();
        repeat (8) @(posedge clk);
        if (view_q.size() != 0)
        begin
            $display("%0t ns: %0d result beats never arrived", $time, view_q.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("floppy_board_glue_logic_unit test passed");
        else
            $display("floppy_board_glue_logic_unit test failed");
        $finish;
    end

endmodule
